[hw/rtl/psl_pkg.sv]
// ----------------------------------------------------------------------------
// psl_pkg
// Shared types and constants for the positional insert list buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package psl_pkg;

  localparam int unsigned PSL_DEPTH = 16;
  localparam int unsigned PSL_CNT_W = 7;
  localparam int unsigned PSL_VAL_W = 32;
  localparam int unsigned PSL_POS_W = 5;
  localparam int unsigned PSL_ECNT_W = 5;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DUMP   = 2'd2
  } psl_req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOB   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } psl_status_e;

  typedef enum logic [1:0] {
    CELL_IDLE   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_ROTATE = 2'd2
  } psl_cell_cmd_e;

  typedef enum logic {
    PSL_IDLE = 1'b0,
    PSL_DUMP = 1'b1
  } psl_state_e;

  typedef struct packed {
    psl_cell_cmd_e        cmd;
    logic [PSL_CNT_W-1:0] at;
    logic [PSL_CNT_W-1:0] count;
  } psl_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/psl_if.sv]
// ----------------------------------------------------------------------------
// psl_in_if / psl_out_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface psl_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         req_type;
  logic [psl_pkg::PSL_POS_W-1:0]      position;
  logic signed [psl_pkg::PSL_VAL_W-1:0] item_value;

  modport source (output valid, req_type, position, item_value, input ready);
  modport sink   (input valid, req_type, position, item_value, output ready);
endinterface

interface psl_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [psl_pkg::PSL_VAL_W-1:0] out_value;
  logic                                 is_last;
  logic [1:0]                           status;
  logic [psl_pkg::PSL_ECNT_W-1:0]       elem_count;

  modport source (output valid, out_value, is_last, status, elem_count, input ready);
  modport sink   (input valid, out_value, is_last, status, elem_count, output ready);
endinterface

`default_nettype wire

[hw/rtl/psl_cell.sv]
// ----------------------------------------------------------------------------
// psl_cell
// One list element; shifts up on insert, rotates down on dump.
// ----------------------------------------------------------------------------
`default_nettype none

module psl_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                                 clk_i,
  input  wire psl_pkg::psl_ctrl_t                   ctrl_i,
  input  wire logic signed [psl_pkg::PSL_VAL_W-1:0] new_i,
  input  wire logic signed [psl_pkg::PSL_VAL_W-1:0] below_i,
  input  wire logic signed [psl_pkg::PSL_VAL_W-1:0] above_i,
  input  wire logic signed [psl_pkg::PSL_VAL_W-1:0] head_i,
  output logic signed [psl_pkg::PSL_VAL_W-1:0]      value_o
);

  localparam logic [psl_pkg::PSL_CNT_W-1:0] IdxC = psl_pkg::PSL_CNT_W'(IDX);
  localparam logic [psl_pkg::PSL_CNT_W-1:0] IdxP1 = psl_pkg::PSL_CNT_W'(IDX + 1);

  logic signed [psl_pkg::PSL_VAL_W-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    unique case (ctrl_i.cmd)
      psl_pkg::CELL_INSERT: begin
        if (IdxC == ctrl_i.at) begin
          value_d = new_i;
        end else if (IdxC > ctrl_i.at && IdxC <= ctrl_i.count) begin
          value_d = below_i;
        end
      end
      psl_pkg::CELL_ROTATE: begin
        if (IdxP1 == ctrl_i.count) begin
          value_d = head_i;
        end else if (IdxP1 < ctrl_i.count) begin
          value_d = above_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

[hw/rtl/positional_insert_list_buffer_unit.sv]
// ----------------------------------------------------------------------------
// positional_insert_list_buffer_unit
// Bounded ordered list of signed 32-bit values held in a chain of cells.
// ----------------------------------------------------------------------------
// An append or insert is accepted in any cycle in which the result register
// is free or being drained; the cell chain shifts in that cycle, and the
// status beat appears in the next cycle. A dump of N elements issues N beats:
// element 0 is read from the head cell and the chain rotates down by one with
// each beat, so the list is back in order when the last beat leaves. No
// request is accepted until a dump has issued its last beat. An empty dump
// answers one status beat. Request code 3 is taken and ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_list_buffer_unit #(
  parameter int unsigned DEPTH = psl_pkg::PSL_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  psl_in_if.sink    in_i,
  psl_out_if.source out_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = psl_pkg::PSL_VAL_W;
  localparam int unsigned KW = psl_pkg::PSL_CNT_W;

  logic signed [VW-1:0] cell_val [DEPTH];
  psl_pkg::psl_ctrl_t   ctrl;

  psl_pkg::psl_state_e  state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        left_q, left_d;
  logic                 out_valid_q, out_valid_d;
  logic signed [VW-1:0] out_value_q, out_value_d;
  logic                 is_last_q, is_last_d;
  psl_pkg::psl_status_e status_q, status_d;
  logic [KW-1:0]        ecount_q, ecount_d;

  logic          slot_free;
  logic          accept;
  logic [KW-1:0] cnt_k;
  logic [KW-1:0] pos_k;
  logic [KW-1:0] at_k;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VW-1:0] below, above;
    if (i == 0) begin : g_first
      assign below = '0;
    end else begin : g_mid_lo
      assign below = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign above = '0;
    end else begin : g_mid_hi
      assign above = cell_val[i+1];
    end
    psl_cell #(.IDX(i)) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .new_i   (in_i.item_value),
      .below_i (below),
      .above_i (above),
      .head_i  (cell_val[0]),
      .value_o (cell_val[i])
    );
  end

  assign slot_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == psl_pkg::PSL_IDLE) && slot_free;
  assign accept     = in_i.valid && in_i.ready;
  assign cnt_k      = KW'(count_q);
  assign pos_k      = KW'(in_i.position);
  assign at_k       = (in_i.req_type == psl_pkg::REQ_APPEND) ? cnt_k : pos_k;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    left_d      = left_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_value_d = out_value_q;
    is_last_d   = is_last_q;
    status_d    = status_q;
    ecount_d    = ecount_q;
    ctrl.cmd    = psl_pkg::CELL_IDLE;
    ctrl.at     = at_k;
    ctrl.count  = cnt_k;

    if (accept) begin
      unique case (in_i.req_type)
        psl_pkg::REQ_APPEND, psl_pkg::REQ_INSERT: begin
          out_valid_d = 1'b1;
          out_value_d = '0;
          is_last_d   = 1'b1;
          ecount_d    = cnt_k;
          if (at_k > cnt_k) begin
            status_d = psl_pkg::ST_OOB;
          end else if (cnt_k >= KW'(DEPTH)) begin
            status_d = psl_pkg::ST_FULL;
          end else begin
            status_d = psl_pkg::ST_OK;
            ctrl.cmd = psl_pkg::CELL_INSERT;
            count_d  = count_q + CW'(1);
            ecount_d = cnt_k + KW'(1);
          end
        end
        psl_pkg::REQ_DUMP: begin
          out_valid_d = 1'b1;
          ecount_d    = cnt_k;
          if (count_q == '0) begin
            out_value_d = '0;
            is_last_d   = 1'b1;
            status_d    = psl_pkg::ST_EMPTY;
          end else begin
            out_value_d = cell_val[0];
            is_last_d   = (count_q == CW'(1));
            status_d    = psl_pkg::ST_OK;
            ctrl.cmd    = psl_pkg::CELL_ROTATE;
            left_d      = count_q - CW'(1);
            if (count_q != CW'(1)) begin
              state_d = psl_pkg::PSL_DUMP;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (state_q == psl_pkg::PSL_DUMP && slot_free) begin
      out_valid_d = 1'b1;
      out_value_d = cell_val[0];
      is_last_d   = (left_q == CW'(1));
      status_d    = psl_pkg::ST_OK;
      ecount_d    = cnt_k;
      ctrl.cmd    = psl_pkg::CELL_ROTATE;
      left_d      = left_q - CW'(1);
      if (left_q == CW'(1)) begin
        state_d = psl_pkg::PSL_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psl_pkg::PSL_IDLE;
      count_q     <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    is_last_q   <= is_last_d;
    status_q    <= status_d;
    ecount_q    <= ecount_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_value  = out_value_q;
  assign out_o.is_last    = is_last_q;
  assign out_o.status     = status_q;
  assign out_o.elem_count = ecount_q[psl_pkg::PSL_ECNT_W-1:0];

endmodule

`default_nettype wire

[hw/rtl/psl_checker.sv]
// ----------------------------------------------------------------------------
// psl_checker
// Port-level checks on result beats of the list buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module psl_checker #(
  parameter int unsigned DEPTH = psl_pkg::PSL_DEPTH
) (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic signed [psl_pkg::PSL_VAL_W-1:0] out_value,
  input wire logic                                 is_last,
  input wire logic [1:0]                           status,
  input wire logic [psl_pkg::PSL_ECNT_W-1:0]       elem_count
);

  localparam logic [psl_pkg::PSL_ECNT_W-1:0] DepthE = psl_pkg::PSL_ECNT_W'(DEPTH);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_status_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status != psl_pkg::ST_OK |-> is_last && out_value == '0)
    else $error("status beat not final or carries a value");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == psl_pkg::ST_FULL |-> elem_count == DepthE)
    else $error("full status with count below depth");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == psl_pkg::ST_EMPTY |-> elem_count == '0)
    else $error("empty status with nonzero count");

endmodule

bind positional_insert_list_buffer_unit psl_checker #(.DEPTH(DEPTH)) u_psl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_value  (out_o.out_value),
  .is_last    (out_o.is_last),
  .status     (out_o.status),
  .elem_count (out_o.elem_count)
);

`default_nettype wire

[test/psl_tb_pkg.sv]
// ----------------------------------------------------------------------------
// psl_tb_pkg
// Scoreboard for the positional insert list buffer. It mirrors the list
// contents and element count, queues the beats that each request should
// produce and checks the result beats field by field, in order.
// ----------------------------------------------------------------------------
package psl_tb_pkg;

  import psl_pkg::*;

  typedef struct packed {
    logic signed [PSL_VAL_W-1:0] value;
    logic                        last;
    psl_status_e                 status;
    logic [PSL_ECNT_W-1:0]       count;
  } psl_result_t;

  class psl_list_scoreboard;
    logic signed [PSL_VAL_W-1:0] cells [PSL_DEPTH];
    int unsigned                 count;
    psl_result_t                 pending [$];
    int unsigned                 errors;
    int unsigned                 requests;
    int unsigned                 beats;
    int unsigned                 dumps;
    int unsigned                 oob_hits;
    int unsigned                 full_hits;
    int unsigned                 empty_hits;

    function void push_status(psl_status_e st);
      psl_result_t r;
      r.value  = '0;
      r.last   = 1'b1;
      r.status = st;
      r.count  = count[PSL_ECNT_W-1:0];
      pending.insert(pending.size(), r);
      case (st)
        ST_OOB:   oob_hits++;
        ST_FULL:  full_hits++;
        ST_EMPTY: empty_hits++;
        default: ;
      endcase
    endfunction

    function void note_request(logic [1:0] req, logic [PSL_POS_W-1:0] pos,
                               logic signed [PSL_VAL_W-1:0] val);
      int unsigned at;
      int unsigned i;
      psl_result_t r;
      requests++;
      if (req == REQ_APPEND || req == REQ_INSERT) begin
        at = (req == REQ_APPEND) ? count : pos;
        if (at > count) begin
          push_status(ST_OOB);
        end else if (count >= PSL_DEPTH) begin
          push_status(ST_FULL);
        end else begin
          for (i = count; i > at; i--) cells[i] = cells[i-1];
          cells[at] = val;
          count++;
          push_status(ST_OK);
        end
      end else if (req == REQ_DUMP) begin
        dumps++;
        if (count == 0) begin
          push_status(ST_EMPTY);
        end else begin
          for (i = 0; i < count; i++) begin
            r.value  = cells[i];
            r.last   = (i + 1 == count);
            r.status = ST_OK;
            r.count  = count[PSL_ECNT_W-1:0];
            pending.insert(pending.size(), r);
          end
        end
      end
    endfunction

    function void check_result(psl_result_t got);
      psl_result_t want;
      beats++;
      if (pending.size() == 0) begin
        $error("unexpected result beat: out_value %0d status %0d elem_count %0d",
               got.value, got.status, got.count);
        errors++;
        return;
      end
      want = pending[0];
      pending.delete(0);
      if (got.value !== want.value) begin
        $error("out_value: expected %0d, actual %0d", want.value, got.value);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("is_last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("elem_count: expected %0d, actual %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

endpackage

[test/positional_insert_list_buffer_unit_tb.sv]
// ----------------------------------------------------------------------------
// positional_insert_list_buffer_unit_tb
// Drives append, insert, dump and unused requests into the list buffer with
// random idle bursts on both channels, predicts every result beat and checks
// each one in order. A directed opening covers the empty list, out of bounds
// inserts, front, middle and end inserts and value extremes; a random phase
// then grows the list to full and keeps working it there.
// ----------------------------------------------------------------------------
module positional_insert_list_buffer_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import psl_pkg::*;
  import psl_tb_pkg::*;

  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 395;
  localparam int unsigned QUIET_TAIL   = 60;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 500_000;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        quiet_phase = 1'b0;
  int unsigned cycle_count = 0;

  logic signed [PSL_VAL_W-1:0] corner_values [4] =
    '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000, 32'shffff_ffff};

  psl_list_scoreboard board = new();

  psl_in_if  req_if ();
  psl_out_if rsp_if ();

  positional_insert_list_buffer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit with %0d beats outstanding",
               board.pending.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin : watch_results
    psl_result_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.value  = rsp_if.out_value;
      got.last   = rsp_if.is_last;
      got.status = psl_status_e'(rsp_if.status);
      got.count  = rsp_if.elem_count;
      board.check_result(got);
    end
  end

  initial begin
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_request(input logic [1:0] req, input logic [PSL_POS_W-1:0] pos,
                              input logic signed [PSL_VAL_W-1:0] val);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= req;
    req_if.position   <= pos;
    req_if.item_value <= val;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    board.note_request(req, pos, val);
  endtask

  initial begin : main
    int unsigned              issued;
    int unsigned              pick;
    logic [1:0]               req;
    logic [PSL_POS_W-1:0]     pos;
    logic signed [PSL_VAL_W-1:0] val;

    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_APPEND;
    req_if.position   <= '0;
    req_if.item_value <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(REQ_DUMP,   5'd0,  32'sd0);
    send_request(REQ_INSERT, 5'd1,  32'sd11);
    send_request(REQ_INSERT, 5'd31, 32'sh7fff_ffff);
    send_request(REQ_INSERT, 5'd0,  32'sh7fff_ffff);
    send_request(REQ_APPEND, 5'd31, 32'sh8000_0000);
    send_request(REQ_INSERT, 5'd1,  32'sd0);
    send_request(REQ_INSERT, 5'd3,  32'shffff_ffff);
    send_request(REQ_INSERT, 5'd0,  32'sh5555_aaaa);
    send_request(REQ_UNUSED, 5'd0,  32'sh1234_5678);
    send_request(REQ_DUMP,   5'd31, 32'shffff_ffff);
    send_request(REQ_APPEND, 5'd0,  32'shaaaa_5555);
    send_request(REQ_INSERT, 5'd7,  32'sd42);
    send_request(REQ_INSERT, 5'd16, 32'sd7);

    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      quiet_phase = (RANDOM_ITEMS - issued) <= QUIET_TAIL;
      pick = $urandom_range(0, 99);
      pos  = PSL_POS_W'($urandom_range(0, 31));
      val  = $urandom();
      if ($urandom_range(0, 9) == 0) val = corner_values[$urandom_range(0, 3)];
      if (pick < 6) begin
        req = REQ_UNUSED;
      end else if (pick < 22) begin
        req = REQ_DUMP;
      end else if (pick < 45) begin
        req = REQ_APPEND;
      end else begin
        req = REQ_INSERT;
        if ($urandom_range(0, 6) != 0) pos = PSL_POS_W'($urandom_range(0, board.count));
      end
      send_request(req, pos, val);
      issued++;
    end
    req_if.valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.pending.size() != 0) begin
      $error("%0d result beats never arrived", board.pending.size());
      board.errors++;
    end
    $display("%0d requests taken, %0d result beats checked over %0d dumps",
             board.requests, board.beats, board.dumps);
    $display("out of bounds %0d, full %0d, empty %0d; final list length %0d",
             board.oob_hits, board.full_hits, board.empty_hits, board.count);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/psl_pkg.sv
hw/rtl/psl_if.sv
hw/rtl/psl_cell.sv
hw/rtl/positional_insert_list_buffer_unit.sv
hw/rtl/psl_checker.sv
test/psl_tb_pkg.sv
test/positional_insert_list_buffer_unit_tb.sv
